// ===== hw/rtl/wpsm_pkg.sv =====
// Package for the wheel pulse speed meter: command codes, field widths and
// saturation limits shared by the core.
// No dependencies.
`timescale 1ns / 1ps

package wpsm_pkg;

  // Field widths
  localparam int CMD_W   = 3;
  localparam int CH_W    = 3;
  localparam int TIME_W  = 32;
  localparam int TICK_W  = 32;
  localparam int MPT_W   = 24;
  localparam int VEL_W   = 40;
  localparam int DIST_W  = 48;
  localparam int PROD_W  = TICK_W + MPT_W;   // pulses * travel per pulse
  localparam int SCALE_W = PROD_W + 10;      // product * 1000
  localparam int QUO_W   = VEL_W;            // quotient bits developed by the divider

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PULSE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DIR    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  // Saturation limits and reset value of the scale register
  localparam logic [VEL_W-1:0]  VEL_POS_MAX    = 40'h7F_FFFF_FFFF;
  localparam logic [VEL_W-1:0]  VEL_NEG_MAX    = 40'h80_0000_0000;
  localparam logic [DIST_W-1:0] DIST_POS_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic [DIST_W-1:0] DIST_NEG_MAX   = 48'h8000_0000_0000;
  localparam logic [DIST_W-1:0] STEP_MAX       = 48'hFFFF_FFFF_FFFF;
  localparam logic [MPT_W-1:0]  TICK_SCALE_RST = 24'd65536;

endpackage

// ===== hw/rtl/wheel_pulse_speed_meter_core.sv =====
// Wheel pulse speed meter core: per-channel pulse counting, direction flags,
// velocity and distance update through one shared restoring divider.
// Depends on wpsm_pkg.
`timescale 1ns / 1ps

// Channel    Ports                                            Transaction
// ---------  -----------------------------------------------  -----------------------
// command    start, busy, in_command, in_channel, in_forward,  start high, busy low
//            in_now_ms
// result     out_valid, out_result_channel, out_velocity,      out_valid high, 1 cycle
//            out_distance, out_lifetime_ticks, out_last
// config     cfg_we, cfg_wdata (travel per pulse)              cfg_we high
//
// Pulse, direction, clear and read are accepted in idle, then executed in ST_EXEC.
// Update walks the channels with one divider: per channel load, scale, 40
// quotient bits and write-back; load, scale and write-back when the quotient
// saturates, and load alone when elapsed time is zero.
// Reset is synchronous, active low, and clears all channel state at once.
// busy stays high while a command executes; results cannot be stalled.

module wheel_pulse_speed_meter_core
  import wpsm_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // command channel
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         in_command,
  input  logic [CH_W-1:0]          in_channel,
  input  logic                     in_forward,
  input  logic [TIME_W-1:0]        in_now_ms,
  // result channel
  output logic                     out_valid,
  output logic [CH_W-1:0]          out_result_channel,
  output logic signed [VEL_W-1:0]  out_velocity,
  output logic signed [DIST_W-1:0] out_distance,
  output logic [TICK_W-1:0]        out_lifetime_ticks,
  output logic                     out_last,
  // configuration
  input  logic                     cfg_we,
  input  logic [MPT_W-1:0]         cfg_wdata
);

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_CH  = CH_W'(CHANNELS - 1);
  localparam logic [5:0]      DIV_LAST = 6'(QUO_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_SCALE,
    ST_DIV,
    ST_WB
  } state_t;

  // Control and working registers
  state_t               state_r, state_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [CH_W-1:0]      ch_r, ch_nxt;
  logic                 fwd_r, fwd_nxt;
  logic [TIME_W-1:0]    now_r, now_nxt;
  logic [MPT_W-1:0]     mpt_r;
  logic [TIME_W-1:0]    dt_r, dt_nxt;
  logic [PROD_W-1:0]    p_r, p_nxt;
  logic [TIME_W-1:0]    rem_r, rem_nxt;
  logic [QUO_W-1:0]     low_r, low_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  logic                 sat_r, sat_nxt;

  // Registered result
  logic                 ov_r, ov_nxt;
  logic [CH_W-1:0]      och_r, och_nxt;
  logic [VEL_W-1:0]     ovel_r, ovel_nxt;
  logic [DIST_W-1:0]    odist_r, odist_nxt;
  logic [TICK_W-1:0]    otick_r, otick_nxt;
  logic                 olast_r, olast_nxt;

  // Channel state
  logic [TICK_W-1:0]    win_r  [CHANNELS];
  logic [TICK_W-1:0]    tot_r  [CHANNELS];
  logic                 rev_r  [CHANNELS];
  logic [VEL_W-1:0]     spd_r  [CHANNELS];
  logic [DIST_W-1:0]    trv_r  [CHANNELS];
  logic [TIME_W-1:0]    prv_r  [CHANNELS];

  // Channel state write controls
  logic                 win_we, tot_we, rev_we, spd_we, trv_we, prv_we;
  logic [TICK_W-1:0]    win_wd, tot_wd;
  logic                 rev_wd;
  logic [VEL_W-1:0]     spd_wd;
  logic [DIST_W-1:0]    trv_wd;
  logic [TIME_W-1:0]    prv_wd;

  // Datapath signals
  logic                 accept;
  logic                 chan_ok;
  logic [IW-1:0]        cidx;
  logic [TICK_W-1:0]    win_rd, tot_rd;
  logic                 rev_rd;
  logic [VEL_W-1:0]     spd_rd;
  logic [DIST_W-1:0]    trv_rd;
  logic [TIME_W-1:0]    prv_rd;
  logic [TIME_W-1:0]    dt_w;
  logic [PROD_W-1:0]    prod_w;
  logic [SCALE_W-1:0]   scaled_w;
  logic                 ovf_w;
  logic [TIME_W:0]      trial_w;
  logic [TIME_W:0]      diff_w;
  logic                 ge_w;
  logic [VEL_W-1:0]     vel_w;
  logic [DIST_W-1:0]    step_w;
  logic [DIST_W+1:0]    dsum_w;
  logic [DIST_W-1:0]    dist_w;

  assign accept  = start && (state_r == ST_IDLE);
  assign busy    = (state_r != ST_IDLE);
  assign chan_ok = ({1'b0, ch_r} < 4'(CHANNELS));
  assign cidx    = ch_r[IW-1:0];

  // Read the addressed channel
  assign win_rd = win_r[cidx];
  assign tot_rd = tot_r[cidx];
  assign rev_rd = rev_r[cidx];
  assign spd_rd = spd_r[cidx];
  assign trv_rd = trv_r[cidx];
  assign prv_rd = prv_r[cidx];

  // Elapsed time and travel product
  assign dt_w   = now_r - prv_rd;
  assign prod_w = PROD_W'(win_rd) * PROD_W'(mpt_r);

  // Scale by 1000 as shift-and-subtract; quotient overflows 40 bits when the top
  // part already reaches the divisor
  assign scaled_w = {p_r, 10'b0} - {6'b0, p_r, 4'b0} - {7'b0, p_r, 3'b0};
  assign ovf_w    = ({6'b0, scaled_w[SCALE_W-1:QUO_W]} >= dt_r);

  // One restoring division step
  assign trial_w = {rem_r, low_r[QUO_W-1]};
  assign diff_w  = trial_w - {1'b0, dt_r};
  assign ge_w    = (trial_w >= {1'b0, dt_r});

  // Signed, saturated velocity from the quotient
  always_comb begin
    if (rev_rd) begin
      if (sat_r || low_r[QUO_W-1]) vel_w = VEL_NEG_MAX;
      else                         vel_w = ~low_r + 40'd1;
    end else begin
      if (sat_r || low_r[QUO_W-1]) vel_w = VEL_POS_MAX;
      else                         vel_w = low_r;
    end
  end

  // Signed, saturated distance
  assign step_w = (|p_r[PROD_W-1:DIST_W]) ? STEP_MAX : p_r[DIST_W-1:0];
  assign dsum_w = rev_rd ? ({{2{trv_rd[DIST_W-1]}}, trv_rd} - {2'b0, step_w})
                         : ({{2{trv_rd[DIST_W-1]}}, trv_rd} + {2'b0, step_w});
  always_comb begin
    if (dsum_w[DIST_W+1:DIST_W-1] == 3'b000 || dsum_w[DIST_W+1:DIST_W-1] == 3'b111) begin
      dist_w = dsum_w[DIST_W-1:0];
    end else if (dsum_w[DIST_W+1]) begin
      dist_w = DIST_NEG_MAX;
    end else begin
      dist_w = DIST_POS_MAX;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    ch_nxt    = ch_r;
    fwd_nxt   = fwd_r;
    now_nxt   = now_r;
    dt_nxt    = dt_r;
    p_nxt     = p_r;
    rem_nxt   = rem_r;
    low_nxt   = low_r;
    cnt_nxt   = cnt_r;
    sat_nxt   = sat_r;
    ov_nxt    = 1'b0;
    och_nxt   = och_r;
    ovel_nxt  = ovel_r;
    odist_nxt = odist_r;
    otick_nxt = otick_r;
    olast_nxt = olast_r;
    win_we = 1'b0; win_wd = '0;
    tot_we = 1'b0; tot_wd = '0;
    rev_we = 1'b0; rev_wd = 1'b0;
    spd_we = 1'b0; spd_wd = '0;
    trv_we = 1'b0; trv_wd = '0;
    prv_we = 1'b0; prv_wd = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt = in_command;
          fwd_nxt = in_forward;
          now_nxt = in_now_ms;
          if (in_command == CMD_UPDATE) begin
            ch_nxt    = '0;
            state_nxt = ST_LOAD;
          end else begin
            ch_nxt    = in_channel;
            state_nxt = ST_EXEC;
          end
        end
      end

      ST_EXEC: begin
        unique case (cmd_r)
          CMD_PULSE: begin
            win_we = chan_ok; win_wd = win_rd + 32'd1;
            tot_we = chan_ok; tot_wd = tot_rd + 32'd1;
          end
          CMD_DIR: begin
            rev_we = chan_ok; rev_wd = !fwd_r;
          end
          CMD_CLEAR: begin
            win_we = chan_ok;
            tot_we = chan_ok;
            spd_we = chan_ok;
            trv_we = chan_ok;
          end
          CMD_READ: begin
            ov_nxt    = 1'b1;
            och_nxt   = ch_r;
            ovel_nxt  = chan_ok ? spd_rd : '0;
            odist_nxt = chan_ok ? trv_rd : '0;
            otick_nxt = chan_ok ? tot_rd : '0;
            olast_nxt = 1'b1;
          end
          default: ;
        endcase
        state_nxt = ST_IDLE;
      end

      ST_LOAD: begin
        dt_nxt = dt_w;
        p_nxt  = prod_w;
        if (dt_w == '0) begin
          // no time elapsed: report stored values and move on
          ov_nxt    = 1'b1;
          och_nxt   = ch_r;
          ovel_nxt  = spd_rd;
          odist_nxt = trv_rd;
          otick_nxt = tot_rd;
          olast_nxt = (ch_r == LAST_CH);
          if (ch_r == LAST_CH) state_nxt = ST_IDLE;
          else                 ch_nxt    = ch_r + 3'd1;
        end else begin
          win_we    = 1'b1;
          state_nxt = ST_SCALE;
        end
      end

      ST_SCALE: begin
        if (ovf_w) begin
          sat_nxt   = 1'b1;
          state_nxt = ST_WB;
        end else begin
          sat_nxt   = 1'b0;
          rem_nxt   = {6'b0, scaled_w[SCALE_W-1:QUO_W]};
          low_nxt   = scaled_w[QUO_W-1:0];
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        // develop one quotient bit, shifted in behind the dividend
        rem_nxt = ge_w ? diff_w[TIME_W-1:0] : trial_w[TIME_W-1:0];
        low_nxt = {low_r[QUO_W-2:0], ge_w};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == DIV_LAST) state_nxt = ST_WB;
      end

      ST_WB: begin
        spd_we = 1'b1; spd_wd = vel_w;
        trv_we = 1'b1; trv_wd = dist_w;
        prv_we = 1'b1; prv_wd = now_r;
        ov_nxt    = 1'b1;
        och_nxt   = ch_r;
        ovel_nxt  = vel_w;
        odist_nxt = dist_w;
        otick_nxt = tot_rd;
        olast_nxt = (ch_r == LAST_CH);
        if (ch_r == LAST_CH) begin
          state_nxt = ST_IDLE;
        end else begin
          ch_nxt    = ch_r + 3'd1;
          state_nxt = ST_LOAD;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state, channel store and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mpt_r   <= TICK_SCALE_RST;
      ov_r    <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        win_r[i] <= '0;
        tot_r[i] <= '0;
        rev_r[i] <= 1'b0;
        spd_r[i] <= '0;
        trv_r[i] <= '0;
        prv_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) mpt_r <= cfg_wdata;
      if (win_we) win_r[cidx] <= win_wd;
      if (tot_we) tot_r[cidx] <= tot_wd;
      if (rev_we) rev_r[cidx] <= rev_wd;
      if (spd_we) spd_r[cidx] <= spd_wd;
      if (trv_we) trv_r[cidx] <= trv_wd;
      if (prv_we) prv_r[cidx] <= prv_wd;
    end
    cmd_r   <= cmd_nxt;
    ch_r    <= ch_nxt;
    fwd_r   <= fwd_nxt;
    now_r   <= now_nxt;
    dt_r    <= dt_nxt;
    p_r     <= p_nxt;
    rem_r   <= rem_nxt;
    low_r   <= low_nxt;
    cnt_r   <= cnt_nxt;
    sat_r   <= sat_nxt;
    och_r   <= och_nxt;
    ovel_r  <= ovel_nxt;
    odist_r <= odist_nxt;
    otick_r <= otick_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid          = ov_r;
  assign out_result_channel = och_r;
  assign out_velocity       = $signed(ovel_r);
  assign out_distance       = $signed(odist_r);
  assign out_lifetime_ticks = otick_r;
  assign out_last           = olast_r;

`ifndef SYNTHESIS
  // An accepted command always occupies the sequencer for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted command did not raise busy");

  // The final result coincides with the sequencer returning to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy) else $error("final result while still busy");

  // More results of an update must still be pending
  a_notlast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy) else $error("update ended without final result");

  // Partial remainder stays below the divisor throughout the division
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < dt_r) else $error("divider remainder out of range");

  // Step counter never runs past the quotient width
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> cnt_r <= DIV_LAST) else $error("divider step count overrun");
`endif

endmodule
